FILE: rtl/ssp_pkg.sv
package ssp_pkg;

  localparam int unsigned MAX_VERTICES = 64;
  localparam int unsigned WEIGHT_BITS  = 16;
  localparam int unsigned VIDX_W       = $clog2(MAX_VERTICES);
  localparam int unsigned VCNT_W       = VIDX_W + 1;
  localparam int unsigned ADJ_AW       = 2 * VIDX_W;
  localparam int unsigned CFG_W        = 7;
  localparam int unsigned CFG_AW       = 1;
  localparam int unsigned SRC_W        = 6;

  localparam logic [WEIGHT_BITS-1:0] NO_EDGE = '1;

  localparam logic [CFG_W-1:0]  VERTEX_COUNT_RST = 7'd64;
  localparam logic [SRC_W-1:0]  SOURCE_RST       = 6'd0;

  localparam logic [CFG_AW-1:0] CFG_IDX_VERTEX_COUNT = 1'd0;
  localparam logic [CFG_AW-1:0] CFG_IDX_SOURCE       = 1'd1;

  localparam logic [1:0] MODE_EDGE  = 2'd0;
  localparam logic [1:0] MODE_RUN   = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]             mode;
    logic [VIDX_W-1:0]      edge_from;
    logic [VIDX_W-1:0]      edge_to;
    logic [WEIGHT_BITS-1:0] edge_weight;
  } in_item_t;

  typedef struct packed {
    logic [VIDX_W-1:0]      vertex_index;
    logic [WEIGHT_BITS-1:0] distance;
    logic [VIDX_W-1:0]      predecessor;
    logic                   last_result;
  } out_item_t;

  typedef struct packed {
    logic                   clear_start;
    logic                   wr_en;
    logic [ADJ_AW-1:0]      wr_addr;
    logic [WEIGHT_BITS-1:0] wr_data;
    logic                   rd_en;
    logic [ADJ_AW-1:0]      rd_addr;
  } adj_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW,
    ST_DRAIN,
    ST_PICK,
    ST_EMIT
  } eng_state_t;

endpackage

FILE: rtl/ssp_adj_store.sv
module ssp_adj_store (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ssp_pkg::adj_ctrl_t                 ctrl,
  output logic                               busy,
  output logic [ssp_pkg::WEIGHT_BITS-1:0]    rd_data
);

  logic [ssp_pkg::WEIGHT_BITS-1:0] adj_mem [ssp_pkg::MAX_VERTICES * ssp_pkg::MAX_VERTICES];
  logic [ssp_pkg::WEIGHT_BITS-1:0] rd_data_r;

  logic                            sweeping_r, sweeping_nxt;
  logic [ssp_pkg::ADJ_AW-1:0]      clr_addr_r, clr_addr_nxt;

  logic                            mem_we;
  logic [ssp_pkg::ADJ_AW-1:0]      mem_waddr;
  logic [ssp_pkg::WEIGHT_BITS-1:0] mem_wdata;
  logic                            diag;

  always_comb begin
    sweeping_nxt = sweeping_r;
    clr_addr_nxt = clr_addr_r;
    if (ctrl.clear_start) begin
      sweeping_nxt = 1'b1;
      clr_addr_nxt = '0;
    end else if (sweeping_r) begin
      clr_addr_nxt = clr_addr_r + ssp_pkg::ADJ_AW'(1);
      if (clr_addr_r == '1) begin
        sweeping_nxt = 1'b0;
      end
    end
  end

  assign diag = (clr_addr_r[ssp_pkg::ADJ_AW-1:ssp_pkg::VIDX_W] ==
                 clr_addr_r[ssp_pkg::VIDX_W-1:0]);

  always_comb begin
    mem_we    = sweeping_r || ctrl.wr_en;
    mem_waddr = sweeping_r ? clr_addr_r : ctrl.wr_addr;
    if (sweeping_r) begin
      mem_wdata = diag ? '0 : ssp_pkg::NO_EDGE;
    end else begin
      mem_wdata = ctrl.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweeping_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      sweeping_r <= sweeping_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      adj_mem[mem_waddr] <= mem_wdata;
    end
    if (ctrl.rd_en) begin
      rd_data_r <= adj_mem[ctrl.rd_addr];
    end
  end

  assign busy    = sweeping_r;
  assign rd_data = rd_data_r;

`ifndef ASSERT_OFF
  a_no_access_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    sweeping_r |-> (!ctrl.rd_en && !ctrl.wr_en && !ctrl.clear_start))
    else $error("adjacency access during clear sweep");

  a_sweep_complete: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(sweeping_r) |-> ($past(clr_addr_r) == '1))
    else $error("clear sweep ended before last entry");
`endif

endmodule

FILE: rtl/ssp_engine.sv
module ssp_engine (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  ssp_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output ssp_pkg::out_item_t                 out_data,
  input  logic [ssp_pkg::CFG_W-1:0]          cfg_vertex_count,
  input  logic [ssp_pkg::SRC_W-1:0]          cfg_source,
  output ssp_pkg::adj_ctrl_t                 adj_ctrl,
  input  logic                               adj_busy,
  input  logic [ssp_pkg::WEIGHT_BITS-1:0]    adj_rd_data
);

  typedef struct packed {
    logic [ssp_pkg::WEIGHT_BITS-1:0] dist_val;
    logic [ssp_pkg::VIDX_W-1:0]      pred;
  } vert_entry_t;

  vert_entry_t vert_mem [ssp_pkg::MAX_VERTICES];
  vert_entry_t vert_rd_r;

  logic                              vert_we;
  logic [ssp_pkg::VIDX_W-1:0]        vert_waddr;
  vert_entry_t                       vert_wdata;
  logic                              vert_re;
  logic [ssp_pkg::VIDX_W-1:0]        vert_raddr;

  ssp_pkg::eng_state_t               state_r, state_nxt;
  logic [ssp_pkg::VCNT_W-1:0]        cnt_r, cnt_nxt;
  logic [ssp_pkg::VCNT_W-1:0]        n_r, n_nxt;
  logic [ssp_pkg::VIDX_W-1:0]        v_r, v_nxt;
  logic [ssp_pkg::WEIGHT_BITS-1:0]   dist_v_r, dist_v_nxt;
  logic [ssp_pkg::WEIGHT_BITS-1:0]   best_r, best_nxt;
  logic [ssp_pkg::VIDX_W-1:0]        pick_r, pick_nxt;
  logic                              found_r, found_nxt;
  logic                              p_vld_r, p_vld_nxt;
  logic [ssp_pkg::VIDX_W-1:0]        p_idx_r, p_idx_nxt;
  logic [ssp_pkg::MAX_VERTICES-1:0]  valid_r, valid_nxt;
  logic [ssp_pkg::MAX_VERTICES-1:0]  visited_r, visited_nxt;
  logic                              pend_r, pend_nxt;
  logic [ssp_pkg::VIDX_W-1:0]        pend_idx_r, pend_idx_nxt;
  logic                              out_vld_r, out_vld_nxt;
  ssp_pkg::out_item_t                out_data_r, out_data_nxt;

  logic                              accept;
  logic                              run_go;
  logic [ssp_pkg::VCNT_W-1:0]        used_n;
  logic                              src_ok;
  logic [ssp_pkg::WEIGHT_BITS-1:0]   old_dist;
  logic [ssp_pkg::WEIGHT_BITS:0]     sum;
  logic                              improve;
  logic [ssp_pkg::WEIGHT_BITS-1:0]   new_dist;
  logic                              cand;
  logic                              load;

  assign in_stall = (state_r != ssp_pkg::ST_IDLE) || adj_busy;
  assign accept   = in_valid && !in_stall;
  assign run_go   = accept && (in_data.mode == ssp_pkg::MODE_RUN);

  always_comb begin
    if (cfg_vertex_count == '0) begin
      used_n = ssp_pkg::VCNT_W'(1);
    end else if (cfg_vertex_count > ssp_pkg::CFG_W'(ssp_pkg::MAX_VERTICES)) begin
      used_n = ssp_pkg::VCNT_W'(ssp_pkg::MAX_VERTICES);
    end else begin
      used_n = ssp_pkg::VCNT_W'(cfg_vertex_count);
    end
  end

  assign src_ok = ssp_pkg::VCNT_W'(cfg_source) < used_n;

  // relax one row entry and track the smallest unvisited distance
  assign old_dist = valid_r[p_idx_r] ? vert_rd_r.dist_val : ssp_pkg::NO_EDGE;
  assign sum      = {1'b0, dist_v_r} + {1'b0, adj_rd_data};
  assign improve  = p_vld_r && ({1'b0, old_dist} > sum);
  assign new_dist = improve ? sum[ssp_pkg::WEIGHT_BITS-1:0] : old_dist;
  assign cand     = p_vld_r && !visited_r[p_idx_r] && (new_dist != ssp_pkg::NO_EDGE) &&
                    (!found_r || (new_dist <= best_r));

  assign load = pend_r && (!out_vld_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ssp_pkg::ST_IDLE: begin
        if (run_go) begin
          state_nxt = src_ok ? ssp_pkg::ST_ROW : ssp_pkg::ST_EMIT;
        end
      end
      ssp_pkg::ST_ROW: begin
        if (cnt_r == n_r - ssp_pkg::VCNT_W'(1)) begin
          state_nxt = ssp_pkg::ST_DRAIN;
        end
      end
      ssp_pkg::ST_DRAIN: begin
        state_nxt = ssp_pkg::ST_PICK;
      end
      ssp_pkg::ST_PICK: begin
        state_nxt = found_r ? ssp_pkg::ST_ROW : ssp_pkg::ST_EMIT;
      end
      ssp_pkg::ST_EMIT: begin
        if ((cnt_r == n_r) && !pend_r) begin
          state_nxt = ssp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ssp_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cnt_nxt      = cnt_r;
    n_nxt        = n_r;
    v_nxt        = v_r;
    dist_v_nxt   = dist_v_r;
    best_nxt     = best_r;
    pick_nxt     = pick_r;
    found_nxt    = found_r;
    valid_nxt    = valid_r;
    visited_nxt  = visited_r;
    p_vld_nxt    = 1'b0;
    p_idx_nxt    = cnt_r[ssp_pkg::VIDX_W-1:0];
    pend_nxt     = pend_r && !load;
    pend_idx_nxt = pend_idx_r;

    vert_re    = 1'b0;
    vert_raddr = cnt_r[ssp_pkg::VIDX_W-1:0];
    vert_we    = 1'b0;
    vert_waddr = p_idx_r;
    vert_wdata = '{dist_val: new_dist, pred: v_r};

    adj_ctrl.clear_start = accept && (in_data.mode == ssp_pkg::MODE_CLEAR);
    adj_ctrl.wr_en       = accept && (in_data.mode == ssp_pkg::MODE_EDGE);
    adj_ctrl.wr_addr     = {in_data.edge_from, in_data.edge_to};
    adj_ctrl.wr_data     = in_data.edge_weight;
    adj_ctrl.rd_en       = 1'b0;
    adj_ctrl.rd_addr     = {v_r, cnt_r[ssp_pkg::VIDX_W-1:0]};

    if (improve) begin
      vert_we            = 1'b1;
      valid_nxt[p_idx_r] = 1'b1;
    end
    if (cand) begin
      found_nxt = 1'b1;
      best_nxt  = new_dist;
      pick_nxt  = p_idx_r;
    end

    out_vld_nxt  = load || (out_vld_r && out_stall);
    out_data_nxt = out_data_r;
    if (load) begin
      out_data_nxt.vertex_index = pend_idx_r;
      out_data_nxt.distance     = valid_r[pend_idx_r] ? vert_rd_r.dist_val : ssp_pkg::NO_EDGE;
      out_data_nxt.predecessor  = valid_r[pend_idx_r] ? vert_rd_r.pred : '0;
      out_data_nxt.last_result  = (({1'b0, pend_idx_r} + ssp_pkg::VCNT_W'(1)) == n_r);
    end

    unique case (state_r)
      ssp_pkg::ST_IDLE: begin
        if (run_go) begin
          n_nxt       = used_n;
          cnt_nxt     = '0;
          valid_nxt   = '0;
          visited_nxt = '0;
          found_nxt   = 1'b0;
          if (src_ok) begin
            v_nxt                   = cfg_source;
            dist_v_nxt              = '0;
            valid_nxt[cfg_source]   = 1'b1;
            visited_nxt[cfg_source] = 1'b1;
            vert_we                 = 1'b1;
            vert_waddr              = cfg_source;
            vert_wdata              = '{dist_val: '0, pred: '0};
          end
        end
      end
      ssp_pkg::ST_ROW: begin
        vert_re        = 1'b1;
        adj_ctrl.rd_en = 1'b1;
        p_vld_nxt      = 1'b1;
        cnt_nxt        = cnt_r + ssp_pkg::VCNT_W'(1);
      end
      ssp_pkg::ST_DRAIN: begin
      end
      ssp_pkg::ST_PICK: begin
        cnt_nxt = '0;
        if (found_r) begin
          v_nxt               = pick_r;
          dist_v_nxt          = best_r;
          visited_nxt[pick_r] = 1'b1;
          found_nxt           = 1'b0;
        end
      end
      ssp_pkg::ST_EMIT: begin
        if ((cnt_r != n_r) && (!pend_r || load)) begin
          vert_re      = 1'b1;
          cnt_nxt      = cnt_r + ssp_pkg::VCNT_W'(1);
          pend_nxt     = 1'b1;
          pend_idx_nxt = cnt_r[ssp_pkg::VIDX_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ssp_pkg::ST_IDLE;
      cnt_r     <= '0;
      n_r       <= '0;
      found_r   <= 1'b0;
      valid_r   <= '0;
      visited_r <= '0;
      p_vld_r   <= 1'b0;
      pend_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      n_r       <= n_nxt;
      found_r   <= found_nxt;
      valid_r   <= valid_nxt;
      visited_r <= visited_nxt;
      p_vld_r   <= p_vld_nxt;
      pend_r    <= pend_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r        <= v_nxt;
    dist_v_r   <= dist_v_nxt;
    best_r     <= best_nxt;
    pick_r     <= pick_nxt;
    p_idx_r    <= p_idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (vert_we) begin
      vert_mem[vert_waddr] <= vert_wdata;
    end
    if (vert_re) begin
      vert_rd_r <= vert_mem[vert_raddr];
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_stage_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    p_vld_r |-> (state_r == ssp_pkg::ST_ROW || state_r == ssp_pkg::ST_DRAIN))
    else $error("relax stage active outside row walk");

  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (vert_we && vert_re) |-> (vert_waddr != vert_raddr))
    else $error("vertex memory read and write hit the same entry");

  a_pick_unvisited: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ssp_pkg::ST_PICK && found_r) |-> !visited_r[pick_r])
    else $error("picked vertex already visited");
`endif

endmodule

FILE: rtl/single_source_shortest_paths_top.sv
// Dense-graph single-source shortest paths with an on-chip adjacency matrix.
// Input channel (in_valid/in_stall/in_data): one transaction per item.
//   mode edge writes one matrix weight in the accepting cycle, one per cycle while in_stall is low.
//   mode clear restores 0 on the diagonal and no-edge elsewhere by a sweep
//   over all MAX_VERTICES*MAX_VERTICES entries (4096), with in_stall high meanwhile.
//   mode run computes distances from the configured source and then emits
//   one result transaction per vertex in use, ascending, last_result on the
//   final one. Mode 3 is taken and ignored.
// Config port (cfg_we/cfg_addr/cfg_wdata): index 0 vertex_count, index 1
//   source_vertex; write only while the block is idle.
// A run reads the matrix row of each settled vertex in state ROW, one entry
//   per cycle from the adjacency memory; DRAIN and PICK then settle the next
//   vertex, then results stream out. Once the last result is in the output register,
//   pend_r clears and the state returns to IDLE, dropping in_stall while that result waits.
// Reset (rst_n low, synchronous) returns the config registers to 64 and 0
//   and starts the clear sweep of all 4096 entries; no input is taken until it ends.
// out_stall holds the output register and pauses the result stream.
module single_source_shortest_paths_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  ssp_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output ssp_pkg::out_item_t               out_data,
  input  logic                             cfg_we,
  input  logic [ssp_pkg::CFG_AW-1:0]       cfg_addr,
  input  logic [ssp_pkg::CFG_W-1:0]        cfg_wdata
);

  logic [ssp_pkg::CFG_W-1:0]       vertex_count_r, vertex_count_nxt;
  logic [ssp_pkg::SRC_W-1:0]       source_r, source_nxt;

  ssp_pkg::adj_ctrl_t              adj_ctrl;
  logic                            adj_busy;
  logic [ssp_pkg::WEIGHT_BITS-1:0] adj_rd_data;

  always_comb begin
    vertex_count_nxt = vertex_count_r;
    source_nxt       = source_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        ssp_pkg::CFG_IDX_VERTEX_COUNT: vertex_count_nxt = cfg_wdata;
        ssp_pkg::CFG_IDX_SOURCE:       source_nxt       = cfg_wdata[ssp_pkg::SRC_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= ssp_pkg::VERTEX_COUNT_RST;
      source_r       <= ssp_pkg::SOURCE_RST;
    end else begin
      vertex_count_r <= vertex_count_nxt;
      source_r       <= source_nxt;
    end
  end

  ssp_adj_store u_adj_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (adj_ctrl),
    .busy    (adj_busy),
    .rd_data (adj_rd_data)
  );

  ssp_engine u_engine (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data         (out_data),
    .cfg_vertex_count (vertex_count_r),
    .cfg_source       (source_r),
    .adj_ctrl         (adj_ctrl),
    .adj_busy         (adj_busy),
    .adj_rd_data      (adj_rd_data)
  );

endmodule
